/* design/dks_pkg.sv */
// ----------------------------------------------------------------------------
// dks_pkg
// Shared constants, codes and control structs for the bounded key set.
// ----------------------------------------------------------------------------
`default_nettype none

package dks_pkg;

    // Set geometry
    localparam int MAX_ENTRIES = 16;
    localparam int KEY_BYTES   = 8;
    localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // Field widths
    localparam int REQ_W   = 2;
    localparam int KEY_W   = 64;
    localparam int IDX_W   = 4;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 5;

    // Stream widths (rounded up to whole bytes)
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 72;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    // Status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_RD,
        S_FINISH
    } state_t;

    // Sequencer to compare unit
    typedef struct packed {
        logic start;
        logic cmp_en;
    } mctl_t;

    // Sequencer to output stage
    typedef struct packed {
        logic             load;
        status_t          status;
        logic             found;
        logic             sel_data;
        logic [CNT_W-1:0] count;
    } resp_t;

endpackage

`default_nettype wire

/* design/dks_ram.sv */
// ----------------------------------------------------------------------------
// dks_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dks_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                                     aclk,
    input  wire logic                                     wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* design/dks_match.sv */
// ----------------------------------------------------------------------------
// dks_match
// Shared key compare unit: holds the request key and accumulates a hit over
// the entries streamed out of the store, one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dks_match #(
    parameter int KEY_W = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire dks_pkg::mctl_t   mctl,
    input  wire logic [KEY_W-1:0] key_in,
    input  wire logic [KEY_W-1:0] rd_data,
    output logic                  hit,
    output logic      [KEY_W-1:0] key_q
);

    logic [KEY_W-1:0] key_reg;
    logic             hit_reg;
    logic             hit_next;

    // Key capture on a new request
    always_ff @(posedge aclk) begin
        if (mctl.start) begin
            key_reg <= key_in;
        end
    end

    // Hit accumulation
    always_comb begin
        hit_next = hit_reg;
        if (mctl.start) begin
            hit_next = 1'b0;
        end else if (mctl.cmp_en && (rd_data == key_reg)) begin
            hit_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else begin
            hit_reg <= hit_next;
        end
    end

    assign hit   = hit_reg;
    assign key_q = key_reg;

    // A new request always starts with a clear hit
    a_hit_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        mctl.start |=> !hit_reg)
        else $error("hit not cleared at request start");

endmodule

`default_nettype wire

/* design/dks_ctrl.sv */
// ----------------------------------------------------------------------------
// dks_ctrl
// Request sequencer: walks the stored entries through the compare unit,
// handles reads, clears and appends, and keeps the entry count.
// ----------------------------------------------------------------------------
`default_nettype none

module dks_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // request side
    input  wire logic                         s_fire,
    input  wire dks_pkg::req_t                req_in,
    input  wire logic [dks_pkg::IDX_W-1:0]    idx_in,
    input  wire logic                         key_zero_in,
    output logic                              s_ready,
    // compare unit
    output dks_pkg::mctl_t                    mctl,
    input  wire logic                         hit,
    // store control
    output logic                              wr_en,
    output logic      [dks_pkg::ADDR_W-1:0]   wr_addr,
    output logic                              rd_en,
    output logic      [dks_pkg::ADDR_W-1:0]   rd_addr,
    // output stage
    input  wire logic                         out_free,
    output dks_pkg::resp_t                    resp
);

    dks_pkg::state_t                state_reg, state_next;
    dks_pkg::req_t                  req_reg;
    logic [dks_pkg::IDX_W-1:0]      idx_reg;
    logic [dks_pkg::ADDR_W-1:0]     ptr_reg, ptr_next;
    logic [dks_pkg::CNT_W-1:0]      count_reg, count_next, count_after;
    logic                           cmp_pend_reg;
    logic                           scan_last;
    logic                           full;
    logic                           in_range_req;
    logic                           idx_in_range;
    logic                           finish_go;
    logic                           do_append;
    dks_pkg::status_t               status_c;

    // Scan progress and range checks
    assign scan_last    = ((dks_pkg::CNT_W'(ptr_reg) + dks_pkg::CNT_W'(1)) == count_reg);
    assign full         = (count_reg >= dks_pkg::CNT_W'(dks_pkg::MAX_ENTRIES));
    assign in_range_req = (dks_pkg::CNT_W'(idx_in) < count_reg);
    assign idx_in_range = (dks_pkg::CNT_W'(idx_reg) < count_reg);
    assign finish_go    = (state_reg == dks_pkg::S_FINISH) && out_free;
    assign do_append    = finish_go && (req_reg == dks_pkg::REQ_INSERT) && !full && !hit;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dks_pkg::S_IDLE: begin
                if (s_fire) begin
                    unique case (req_in)
                        dks_pkg::REQ_INSERT, dks_pkg::REQ_LOOKUP: begin
                            if (key_zero_in || (count_reg == '0)) begin
                                state_next = dks_pkg::S_FINISH;
                            end else begin
                                state_next = dks_pkg::S_SCAN;
                            end
                        end
                        dks_pkg::REQ_CLEAR: begin
                            state_next = dks_pkg::S_FINISH;
                        end
                        dks_pkg::REQ_READ: begin
                            state_next = in_range_req ? dks_pkg::S_RD : dks_pkg::S_FINISH;
                        end
                        default: begin
                            state_next = dks_pkg::S_FINISH;
                        end
                    endcase
                end
            end
            dks_pkg::S_SCAN: begin
                if (scan_last) begin
                    state_next = dks_pkg::S_DRAIN;
                end
            end
            dks_pkg::S_DRAIN: begin
                state_next = dks_pkg::S_FINISH;
            end
            dks_pkg::S_RD: begin
                state_next = dks_pkg::S_FINISH;
            end
            dks_pkg::S_FINISH: begin
                if (out_free) begin
                    state_next = dks_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = dks_pkg::S_IDLE;
            end
        endcase
    end

    // Scan pointer
    always_comb begin
        ptr_next = ptr_reg;
        if (s_fire) begin
            ptr_next = '0;
        end else if (state_reg == dks_pkg::S_SCAN) begin
            ptr_next = ptr_reg + dks_pkg::ADDR_W'(1);
        end
    end

    // Result status
    always_comb begin
        status_c = dks_pkg::ST_OK;
        unique case (req_reg)
            dks_pkg::REQ_INSERT: begin
                if (full) begin
                    status_c = dks_pkg::ST_FULL;
                end else if (hit) begin
                    status_c = dks_pkg::ST_PRESENT;
                end
            end
            dks_pkg::REQ_READ: begin
                if (!idx_in_range) begin
                    status_c = dks_pkg::ST_RANGE;
                end
            end
            default: begin
                status_c = dks_pkg::ST_OK;
            end
        endcase
    end

    // Entry count
    always_comb begin
        count_after = count_reg;
        if (req_reg == dks_pkg::REQ_CLEAR) begin
            count_after = '0;
        end else if (do_append) begin
            count_after = count_reg + dks_pkg::CNT_W'(1);
        end
        count_next = finish_go ? count_after : count_reg;
    end

    // Outputs
    always_comb begin
        s_ready       = (state_reg == dks_pkg::S_IDLE);
        mctl.start    = s_fire;
        mctl.cmp_en   = cmp_pend_reg;
        rd_en         = (state_reg == dks_pkg::S_SCAN) || (state_reg == dks_pkg::S_RD);
        rd_addr       = (state_reg == dks_pkg::S_SCAN) ? ptr_reg
                                                        : dks_pkg::ADDR_W'(idx_reg);
        wr_en         = do_append;
        wr_addr       = count_reg[dks_pkg::ADDR_W-1:0];
        resp.load     = finish_go;
        resp.status   = status_c;
        resp.found    = hit;
        resp.sel_data = (req_reg == dks_pkg::REQ_READ) && idx_in_range;
        resp.count    = count_after;
    end

    // Request capture
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg <= req_in;
            idx_reg <= idx_in;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dks_pkg::S_IDLE;
            ptr_reg      <= '0;
            count_reg    <= '0;
            cmp_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            count_reg    <= count_next;
            cmp_pend_reg <= (state_reg == dks_pkg::S_SCAN);
        end
    end

    // Count stays within the set size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= dks_pkg::CNT_W'(dks_pkg::MAX_ENTRIES))
        else $error("entry count above set size");

    // An append grows the count by exactly one
    a_append_count: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> (count_reg == $past(count_reg) + dks_pkg::CNT_W'(1)))
        else $error("append did not bump the count");

    // The scan only touches stored entries
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dks_pkg::S_SCAN) |-> (dks_pkg::CNT_W'(ptr_reg) < count_reg))
        else $error("scan pointer past the count");

endmodule

`default_nettype wire

/* design/bounded_dedup_key_set.sv */
// ----------------------------------------------------------------------------
// bounded_dedup_key_set
// Bounded insertion-ordered key set with duplicate check, lookup, clear and
// indexed read, built around one shared key comparator.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive as beats on the s_ channel; each yields exactly one
//   result beat on the m_ channel (status, found, entry count, entry data).
//   Insert and lookup walk the stored entries through the single comparator,
//   one entry per cycle from the store's read port. With entries stored (and
//   a key whose first byte is non-zero) the scan is followed by a drain step
//   for the last compare, then the result register loads; the next beat is
//   accepted only once the sequencer is back in idle, after that load.
//   Clear, out-of-range read, and insert/lookup on an empty set or with a
//   zero-first-byte key go straight to the result load; an in-range read
//   passes through a read step first. s_tready is high only while the
//   sequencer is idle, so one request is in flight at a time.
//   The result sits in an output register; the next request may be accepted
//   while it waits. If the receiver stalls, the following request finishes
//   its work and then holds until the register is free.
//   Reset empties the set (count zero) and drops any pending result; the
//   entry store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_dedup_key_set #(
    parameter int KEY_BYTES = dks_pkg::KEY_BYTES
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // request: req_type[1:0], key[65:2], index[69:66], zero pad
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [dks_pkg::S_TDATA_W-1:0]   s_tdata,
    // result: status[1:0], found[2], entry_count[7:3], entry_data[71:8]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [dks_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int KW = 8 * KEY_BYTES;

    logic                              s_fire;
    dks_pkg::req_t                     s_req;
    logic [dks_pkg::KEY_W-1:0]         s_key;
    logic [dks_pkg::IDX_W-1:0]         s_idx;
    logic [KW-1:0]                     key_in;

    dks_pkg::mctl_t                    mctl;
    dks_pkg::resp_t                    resp;
    logic                              hit;
    logic [KW-1:0]                     key_q;
    logic [KW-1:0]                     rd_data;
    logic                              wr_en;
    logic                              rd_en;
    logic [dks_pkg::ADDR_W-1:0]        wr_addr;
    logic [dks_pkg::ADDR_W-1:0]        rd_addr;
    logic                              out_free;

    logic                              m_valid_reg;
    dks_pkg::status_t                  m_status_reg;
    logic                              m_found_reg;
    logic [dks_pkg::CNT_W-1:0]         m_count_reg;
    logic [dks_pkg::KEY_W-1:0]         m_data_reg;

    // Request unpacking; only the low KEY_BYTES bytes of the key count
    assign s_req  = dks_pkg::req_t'(s_tdata[1:0]);
    assign s_key  = s_tdata[65:2];
    assign s_idx  = s_tdata[69:66];
    assign key_in = s_key[KW-1:0];
    assign s_fire = s_tvalid && s_tready;

    // Sequencer
    dks_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_fire      (s_fire),
        .req_in      (s_req),
        .idx_in      (s_idx),
        .key_zero_in (key_in[7:0] == 8'd0),
        .s_ready     (s_tready),
        .mctl        (mctl),
        .hit         (hit),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .out_free    (out_free),
        .resp        (resp)
    );

    // Shared comparator
    dks_match #(
        .KEY_W (KW)
    ) u_match (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mctl    (mctl),
        .key_in  (key_in),
        .rd_data (rd_data),
        .hit     (hit),
        .key_q   (key_q)
    );

    // Entry store
    dks_ram #(
        .WIDTH (KW),
        .DEPTH (dks_pkg::MAX_ENTRIES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (key_q),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Result register
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (resp.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (resp.load) begin
            m_status_reg <= resp.status;
            m_found_reg  <= resp.found;
            m_count_reg  <= resp.count;
            m_data_reg   <= resp.sel_data ? dks_pkg::KEY_W'(rd_data) : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_data_reg, m_count_reg, m_found_reg, m_status_reg};

    // A finished result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !resp.load)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

/* sim/bounded_dedup_key_set_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_dedup_key_set_tb
// Self-checking bench for the bounded key set. Request beats are driven on
// the s_ channel and mirrored into a shadow copy of the set, which works out
// the result beat that each one should give. Result beats on the m_ channel
// are compared field by field, in order. Directed tests cover the empty set,
// keys with a zero first byte, duplicates, a full set and clear. Random
// traffic with idle and stall bursts on both sides follows.
// ----------------------------------------------------------------------------

module bounded_dedup_key_set_tb;

    localparam int RESET_CYCLES   = 7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 25;
    localparam int KEY_POOL_SIZE  = 20;

    // One result beat, as the shadow set predicts it
    typedef struct packed {
        dks_pkg::status_t          status;
        logic                      found;
        logic [dks_pkg::CNT_W-1:0] count;
        logic [dks_pkg::KEY_W-1:0] data;
    } set_result_t;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    // request: req_type[1:0], key[65:2], index[69:66], zero pad
    logic [dks_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    // result: status[1:0], found[2], entry_count[7:3], entry_data[71:8]
    logic [dks_pkg::M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the set
    logic [dks_pkg::KEY_W-1:0] shadow_keys [dks_pkg::MAX_ENTRIES];
    int unsigned               shadow_count = 0;

    set_result_t               pending_results [$];
    logic [dks_pkg::KEY_W-1:0] key_pool [KEY_POOL_SIZE];
    int unsigned               mismatches   = 0;
    int unsigned               quiet_cycles = 0;
    bit                        idling_on    = 1'b1;
    bit                        quiet_tail   = 1'b0;

    bounded_dedup_key_set dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one request to the shadow set and return the beat it should give
    function automatic set_result_t apply_set_request(dks_pkg::req_t op,
                                                      logic [dks_pkg::KEY_W-1:0] key,
                                                      logic [dks_pkg::IDX_W-1:0] idx);
        set_result_t res;
        logic        hit;
        res        = '0;
        res.status = dks_pkg::ST_OK;
        hit        = 1'b0;
        // a key whose first byte is zero never matches
        if (key[7:0] != 8'h00) begin
            for (int i = 0; i < shadow_count; i++) begin
                if (shadow_keys[i] == key)
                    hit = 1'b1;
            end
        end
        case (op)
            dks_pkg::REQ_INSERT: begin
                res.found = hit;
                if (shadow_count >= dks_pkg::MAX_ENTRIES) begin
                    res.status = dks_pkg::ST_FULL;
                end else if (hit) begin
                    res.status = dks_pkg::ST_PRESENT;
                end else begin
                    shadow_keys[shadow_count] = key;
                    shadow_count++;
                end
            end
            dks_pkg::REQ_LOOKUP: begin
                res.found = hit;
            end
            dks_pkg::REQ_CLEAR: begin
                shadow_count = 0;
            end
            default: begin
                if (idx < shadow_count)
                    res.data = shadow_keys[idx];
                else
                    res.status = dks_pkg::ST_RANGE;
            end
        endcase
        res.count = shadow_count[dks_pkg::CNT_W-1:0];
        return res;
    endfunction

    // Drive one request beat, with an occasional idle burst ahead of it
    task automatic send_req(dks_pkg::req_t op, logic [dks_pkg::KEY_W-1:0] key,
                            logic [dks_pkg::IDX_W-1:0] idx);
        set_result_t predicted;
        if ($urandom_range(0, 99) == 0)
            idling_on = !idling_on;
        if (idling_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, idx, key, op};
        do
            @(posedge aclk);
        while (!s_tready);
        predicted       = apply_set_request(op, key, idx);
        pending_results = {pending_results, predicted};
    endtask

    // Hold the sender off until every outstanding result has arrived
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Half pool keys so that duplicates are common
    function automatic logic [dks_pkg::KEY_W-1:0] rand_key();
        logic [dks_pkg::KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                k = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
            end
            4: begin
                k       = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
                k[7:0]  = 8'h00;
            end
            default: begin
                k = {$urandom, $urandom};
            end
        endcase
        return k;
    endfunction

    task automatic test_empty_set();
        send_req(dks_pkg::REQ_READ, {$urandom, $urandom}, 4'd15);
        send_req(dks_pkg::REQ_LOOKUP, {$urandom, $urandom} | 64'h1, 4'd0);
        send_req(dks_pkg::REQ_CLEAR, '0, 4'd0);
    endtask

    task automatic test_zero_first_byte();
        // both copies append, neither is seen as present
        send_req(dks_pkg::REQ_INSERT, 64'h1234_5678_9abc_de00, 4'd0);
        send_req(dks_pkg::REQ_INSERT, 64'h1234_5678_9abc_de00, 4'd0);
        send_req(dks_pkg::REQ_LOOKUP, 64'h1234_5678_9abc_de00, 4'd0);
        send_req(dks_pkg::REQ_INSERT, 64'h0, 4'd0);
    endtask

    task automatic test_duplicates();
        send_req(dks_pkg::REQ_INSERT, '1, 4'd0);
        send_req(dks_pkg::REQ_INSERT, '1, 4'd0);
        send_req(dks_pkg::REQ_LOOKUP, '1, 4'd0);
        // index equal to the count is just out of range
        send_req(dks_pkg::REQ_READ, '0, shadow_count[dks_pkg::IDX_W-1:0]);
    endtask

    task automatic test_full_set();
        while (shadow_count < dks_pkg::MAX_ENTRIES)
            send_req(dks_pkg::REQ_INSERT, {$urandom, $urandom} | 64'h1, 4'd0);
        // full wins over duplicate, found still reports the match
        send_req(dks_pkg::REQ_INSERT, '1, 4'd0);
        send_req(dks_pkg::REQ_READ, '0, 4'd15);
        wait_for_results();
    endtask

    task automatic test_clear();
        send_req(dks_pkg::REQ_CLEAR, '0, 4'd0);
        send_req(dks_pkg::REQ_READ, '0, 4'd0);
        send_req(dks_pkg::REQ_LOOKUP, '1, 4'd0);
    endtask

    task automatic test_random_traffic(int unsigned n_items, int unsigned drain_every);
        int unsigned               pick;
        logic [dks_pkg::IDX_W-1:0] idx;
        for (int unsigned i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            idx  = dks_pkg::IDX_W'($urandom_range(0, 15));
            if (shadow_count > 0 && $urandom_range(0, 1) == 1)
                idx = dks_pkg::IDX_W'($urandom_range(0, shadow_count - 1));
            if (pick < 45)
                send_req(dks_pkg::REQ_INSERT, rand_key(), idx);
            else if (pick < 73)
                send_req(dks_pkg::REQ_LOOKUP, rand_key(), idx);
            else if (pick < 98)
                send_req(dks_pkg::REQ_READ, rand_key(), idx);
            else
                send_req(dks_pkg::REQ_CLEAR, rand_key(), idx);
            if (drain_every != 0 && i % drain_every == drain_every - 1)
                wait_for_results();
        end
    endtask

    // Compare one field of a result beat
    function automatic void check_field(string name, logic [dks_pkg::KEY_W-1:0] want,
                                        logic [dks_pkg::KEY_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Result beats against the oldest prediction
    always @(posedge aclk) begin : result_check
        set_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, actual %h",
                         $time, m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, m_tdata[1:0]);
                check_field("found", want.found, m_tdata[2]);
                check_field("entry_count", want.count, m_tdata[7:3]);
                check_field("entry_data", want.data, m_tdata[71:8]);
            end
        end
    end

    // Receiver with random stall bursts
    initial begin : result_sink
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (idling_on && !quiet_tail && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Ends the run when no beat moves on either side for too long
    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : test_sequence
        s_tvalid = 1'b0;
        s_tdata  = '0;
        aresetn  = 1'b0;
        // every fifth pool key has a zero first byte
        for (int i = 0; i < KEY_POOL_SIZE; i++) begin
            key_pool[i] = {$urandom, $urandom};
            if (i % 5 == 0)
                key_pool[i][7:0] = 8'h00;
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_set();
        test_zero_first_byte();
        test_duplicates();
        test_full_set();
        test_clear();
        test_random_traffic(1500, 400);
        // no idling over the last stretch
        quiet_tail = 1'b1;
        test_random_traffic(322, 0);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
design/dks_pkg.sv
design/dks_ram.sv
design/dks_match.sv
design/dks_ctrl.sv
design/bounded_dedup_key_set.sv
sim/bounded_dedup_key_set_tb.sv
